[sv/srts_pkg.sv]
// ----------------------------------------------------------------------------
// srts_pkg
// Shared types and constants of the sorted range table search block.
// ----------------------------------------------------------------------------
`default_nettype none

package srts_pkg;

  localparam int SLOT_W    = 12;
  localparam int COUNT_W   = 13;
  localparam int ADDR_W    = 32;
  localparam int OFFSET_W  = 33;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = 2;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_TABLE_PRESENT     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT       = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TABLE_FILE_OFFSET = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] range_end;
    logic [ADDR_W-1:0] range_start;
  } entry_t;

  typedef struct packed {
    logic               table_present;
    logic [COUNT_W-1:0] entry_count;
    logic [ADDR_W-1:0]  table_file_offset;
  } cfg_t;

endpackage

`default_nettype wire

[sv/srts_req_if.sv]
// ----------------------------------------------------------------------------
// srts_req_if
// Request channel: table loads and address lookups.
// ----------------------------------------------------------------------------
`default_nettype none

interface srts_req_if;
  import srts_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [SLOT_W-1:0] entry_slot;
  logic [ADDR_W-1:0] range_start;
  logic [ADDR_W-1:0] range_end;
  logic [ADDR_W-1:0] lookup_address;

  modport source (
    output valid, func, entry_slot, range_start, range_end, lookup_address,
    input  ready
  );

  modport sink (
    input  valid, func, entry_slot, range_start, range_end, lookup_address,
    output ready
  );

endinterface

`default_nettype wire

[sv/srts_rsp_if.sv]
// ----------------------------------------------------------------------------
// srts_rsp_if
// Response channel: one transaction per lookup.
// ----------------------------------------------------------------------------
`default_nettype none

interface srts_rsp_if;
  import srts_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic [SLOT_W-1:0]   found_slot;
  logic [OFFSET_W-1:0] entry_file_offset;

  modport source (
    output valid, hit, found_slot, entry_file_offset,
    input  ready
  );

  modport sink (
    input  valid, hit, found_slot, entry_file_offset,
    output ready
  );

endinterface

`default_nettype wire

[sv/srts_table.sv]
// ----------------------------------------------------------------------------
// srts_table
// Range table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srts_table #(
  parameter int DEPTH = 4096
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  srts_pkg::entry_t                             wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output srts_pkg::entry_t                             rd_data
);
  import srts_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[sv/srts_regs.sv]
// ----------------------------------------------------------------------------
// srts_regs
// APB configuration registers: table presence, entry count, file offset.
// ----------------------------------------------------------------------------
`default_nettype none

module srts_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [srts_pkg::PADDR_W-1:0] paddr,
  input  wire logic [srts_pkg::DATA_W-1:0]  pwdata,
  output logic      [srts_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output srts_pkg::cfg_t                    cfg
);
  import srts_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_stb;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_stb  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_stb) begin
      unique case (reg_idx)
        REG_TABLE_PRESENT:     cfg.table_present     <= pwdata[0];
        REG_ENTRY_COUNT:       cfg.entry_count       <= pwdata[COUNT_W-1:0];
        REG_TABLE_FILE_OFFSET: cfg.table_file_offset <= pwdata[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TABLE_PRESENT:     prdata = {{(DATA_W-1){1'b0}}, cfg.table_present};
      REG_ENTRY_COUNT:       prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg.entry_count};
      REG_TABLE_FILE_OFFSET: prdata = cfg.table_file_offset;
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/srts_engine.sv]
// ----------------------------------------------------------------------------
// srts_engine
// Search sequencer: bisects the range table with one shared compare unit
// and holds the response in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srts_engine #(
  parameter int MAX_ENTRIES = 4096,
  parameter int ENTRY_BYTES = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  srts_pkg::cfg_t   cfg,
  srts_req_if.sink         req,
  srts_rsp_if.source       rsp,
  output logic             wr_en,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] wr_addr,
  output srts_pkg::entry_t wr_data,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] rd_addr,
  input  srts_pkg::entry_t rd_data
);
  import srts_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  lo, lo_next;
  logic [CNT_W-1:0]  hi, hi_next;
  logic [CNT_W-1:0]  mid, mid_next;
  logic [IDX_W-1:0]  pick, pick_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic              res_hit, res_hit_next;

  logic                out_valid;
  logic                out_hit;
  logic [SLOT_W-1:0]   out_slot;
  logic [OFFSET_W-1:0] out_offset;

  logic             accept;
  logic             emit;
  logic [CNT_W-1:0] count_sat;
  logic [31:0]      slot_ext;
  logic [31:0]      pick_ext;
  logic [CNT_W:0]   sum_n;
  logic             lt;
  logic             gt;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid & req.ready;
  assign emit      = (state == S_EMIT) && (!out_valid || rsp.ready);

  always_comb begin
    if (32'(cfg.entry_count) > 32'(MAX_ENTRIES)) begin
      count_sat = CNT_W'(MAX_ENTRIES);
    end else begin
      count_sat = CNT_W'(cfg.entry_count);
    end
  end

  assign slot_ext = 32'(req.entry_slot);
  assign wr_en    = accept && (req.func == FUNC_LOAD) && (slot_ext < 32'(MAX_ENTRIES));
  assign wr_addr  = slot_ext[IDX_W-1:0];
  assign wr_data  = '{range_end: req.range_end, range_start: req.range_start};

  // shared compare unit
  assign lt = addr < rd_data.range_start;
  assign gt = rd_data.range_start < addr;

  always_comb begin
    state_next   = state;
    lo_next      = lo;
    hi_next      = hi;
    mid_next     = mid;
    pick_next    = pick;
    addr_next    = addr;
    res_hit_next = res_hit;
    rd_addr      = '0;
    sum_n        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && (req.func == FUNC_LOOKUP)) begin
          addr_next    = req.lookup_address;
          lo_next      = '0;
          hi_next      = count_sat;
          pick_next    = '0;
          res_hit_next = 1'b0;
          if (!cfg.table_present || (count_sat == '0)) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (lt) begin
          state_next = S_EMIT;
        end else begin
          sum_n      = {1'b0, lo} + {1'b0, hi};
          mid_next   = sum_n[CNT_W:1];
          rd_addr    = mid_next[IDX_W-1:0];
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!lt && !gt) begin
          pick_next  = mid[IDX_W-1:0];
          rd_addr    = pick_next;
          state_next = S_CHECK;
        end else begin
          if (gt) begin
            lo_next = mid;
          end
          if (lt) begin
            hi_next = mid;
          end
          if (({1'b0, lo_next} + (CNT_W+1)'(1)) >= {1'b0, hi_next}) begin
            pick_next  = lo_next[IDX_W-1:0];
            rd_addr    = pick_next;
            state_next = S_CHECK;
          end else begin
            sum_n    = {1'b0, lo_next} + {1'b0, hi_next};
            mid_next = sum_n[CNT_W:1];
            rd_addr  = mid_next[IDX_W-1:0];
          end
        end
      end
      S_CHECK: begin
        res_hit_next = !lt && (addr < rd_data.range_end);
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    lo      <= lo_next;
    hi      <= hi_next;
    mid     <= mid_next;
    pick    <= pick_next;
    addr    <= addr_next;
    res_hit <= res_hit_next;
  end

  assign pick_ext = 32'(pick);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_hit <= res_hit;
      if (res_hit) begin
        out_slot   <= pick_ext[SLOT_W-1:0];
        out_offset <= OFFSET_W'(cfg.table_file_offset)
                      + OFFSET_W'(pick) * OFFSET_W'(ENTRY_BYTES);
      end else begin
        out_slot   <= '0;
        out_offset <= '0;
      end
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.hit               = out_hit;
  assign rsp.found_slot        = out_slot;
  assign rsp.entry_file_offset = out_offset;

  a_probe_bounds : assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (lo <= mid) && (mid < hi))
    else $error("probe index outside search bounds");

  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.hit) |-> (rsp.found_slot == '0) && (rsp.entry_file_offset == '0))
    else $error("miss response carries nonzero slot or offset");

  a_absent_miss : assert property (@(posedge clk) disable iff (rst)
    (accept && (req.func == FUNC_LOOKUP) && !cfg.table_present && !rsp.valid)
      |=> ##1 (rsp.valid && !rsp.hit))
    else $error("lookup on absent table did not miss in two cycles");

endmodule

`default_nettype wire

[sv/sorted_range_table_search_top.sv]
// ----------------------------------------------------------------------------
// sorted_range_table_search_top
// Range table lookup by bisection over a sorted table of address ranges.
//
// Usage:
//   req carries one transaction per item. func = load writes entry_slot with
//   range_start/range_end and gives no response. func = lookup
//   searches the table for lookup_address and gives one rsp transaction.
//   The APB port sets table_present, entry_count and table_file_offset;
//   write it only while the block is idle.
// Search sequence:
//   A lookup makes one table read per bisection step through the single
//   read port of the table memory, then one read for the range check, and
//   then registers the response. A lookup on an absent or empty table
//   reads no table entry and goes straight to the response. req.ready is
//   low while a lookup is in progress.
// Reset and stall:
//   Reset clears the registers and the sequencer; table contents are kept
//   and are valid only once written. A finished response waits in the output
//   register; new transactions are taken meanwhile, and the next lookup
//   holds at its end until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_range_table_search_top #(
  parameter int MAX_ENTRIES = 4096,
  parameter int ENTRY_BYTES = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  srts_req_if.sink                          req,
  srts_rsp_if.source                        rsp,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [srts_pkg::PADDR_W-1:0] paddr,
  input  wire logic [srts_pkg::DATA_W-1:0]  pwdata,
  output logic      [srts_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);
  import srts_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  cfg_t             cfg;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  srts_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srts_table #(
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  srts_engine #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ENTRY_BYTES (ENTRY_BYTES)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .req     (req),
    .rsp     (rsp),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
